/* sv/wmrd_pkg.sv */
// Shared types, widths and helpers for the window move region diff block.
package wmrd_pkg;

  localparam int COORD_BITS    = 16;
  localparam int SIZE_BITS     = COORD_BITS - 1;
  localparam int EXT_BITS      = COORD_BITS + 2;
  localparam int NUM_SLOTS     = 8;
  localparam int SLOT_IDX_BITS = $clog2(NUM_SLOTS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]         size_t_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic [NUM_SLOTS-1:0]         slot_mask_t;
  typedef logic [SLOT_IDX_BITS-1:0]     slot_idx_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    size_t_t w;
    size_t_t h;
    logic    add;
  } region_t;

  function automatic region_t mk_region(ext_t x, ext_t y, ext_t w, ext_t h, logic add);
    region_t r;
    r.x   = x[COORD_BITS-1:0];
    r.y   = y[COORD_BITS-1:0];
    r.w   = w[SIZE_BITS-1:0];
    r.h   = h[SIZE_BITS-1:0];
    r.add = add;
    return r;
  endfunction

endpackage

/* sv/window_move_region_diff.sv */
// Top level: splits a window move into removed and added rectangles, one per cycle while
// out_ready is high. An input is first registered into the slot and pending registers;
// its first region then moves into the output register. The next input is taken in the
// cycle the last region of the previous one enters the output register.
// Reset (synchronous, rst_n low): stored window becomes empty at (0,0), pending
// regions and the output register are dropped.
module window_move_region_diff
  import wmrd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_BITS-1:0] in_new_x,
  input  logic signed [COORD_BITS-1:0] in_new_y,
  input  logic [SIZE_BITS-1:0]        in_new_w,
  input  logic [SIZE_BITS-1:0]        in_new_h,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS-1:0] out_region_x,
  output logic signed [COORD_BITS-1:0] out_region_y,
  output logic [SIZE_BITS-1:0]        out_region_w,
  output logic [SIZE_BITS-1:0]        out_region_h,
  output logic                        out_is_addition,
  output logic                        out_last_region
);

  coord_t     old_x_r, old_y_r;
  size_t_t    old_w_r, old_h_r;
  region_t    slot_r [NUM_SLOTS];
  region_t    slot_nxt [NUM_SLOTS];
  slot_mask_t pend_r, pend_nxt, new_mask, pend_clr, pend_rem;
  slot_idx_t  pick_idx;
  region_t    out_reg_r;
  logic       out_valid_r, out_last_r;
  logic       in_acc, out_load;

  ext_t ox, oy, ow, oh, nx, ny, nw, nh;
  ext_t ox2, oy2, nx2, ny2, ix0, ix1, ys, yl, sh;
  logic old_ne, new_ne, overlap;

  always_comb begin
    ox  = ext_t'(old_x_r);
    oy  = ext_t'(old_y_r);
    ow  = ext_t'(old_w_r);
    oh  = ext_t'(old_h_r);
    nx  = ext_t'(in_new_x);
    ny  = ext_t'(in_new_y);
    nw  = ext_t'(in_new_w);
    nh  = ext_t'(in_new_h);
    ox2 = ox + ow;
    oy2 = oy + oh;
    nx2 = nx + nw;
    ny2 = ny + nh;
    ix0 = (ox > nx) ? ox : nx;
    ix1 = (ox2 < nx2) ? ox2 : nx2;
    ys  = (oy > ny) ? oy : ny;
    yl  = (oy2 < ny2) ? oy2 : ny2;
    sh  = yl - ys;
    old_ne  = (old_w_r != '0) && (old_h_r != '0);
    new_ne  = (in_new_w != '0) && (in_new_h != '0);
    overlap = old_ne && new_ne && (ix1 > ix0) && (yl > ys);
  end

  always_comb begin
    slot_nxt[0] = mk_region(ox, oy, ow, ny - oy, 1'b0);
    slot_nxt[1] = mk_region(ox, ny2, ow, oy2 - ny2, 1'b0);
    slot_nxt[2] = mk_region(ox, ys, nx - ox, sh, 1'b0);
    slot_nxt[3] = mk_region(nx2, ys, ox2 - nx2, sh, 1'b0);
    slot_nxt[4] = mk_region(nx, ny, nw, oy - ny, 1'b1);
    slot_nxt[5] = mk_region(nx, oy2, nw, ny2 - oy2, 1'b1);
    slot_nxt[6] = mk_region(nx, ys, ox - nx, sh, 1'b1);
    slot_nxt[7] = mk_region(ox2, ys, nx2 - ox2, sh, 1'b1);
    new_mask[0] = oy < ny;
    new_mask[1] = ny2 < oy2;
    new_mask[2] = ox < nx;
    new_mask[3] = nx2 < ox2;
    new_mask[4] = ny < oy;
    new_mask[5] = oy2 < ny2;
    new_mask[6] = nx < ox;
    new_mask[7] = ox2 < nx2;
    if (!overlap) begin
      // disjoint or empty: whole old window out, whole new window in
      slot_nxt[0] = mk_region(ox, oy, ow, oh, 1'b0);
      slot_nxt[1] = mk_region(nx, ny, nw, nh, 1'b1);
      new_mask    = '0;
      new_mask[0] = old_ne;
      new_mask[1] = new_ne;
    end
  end

  always_comb begin
    pick_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick_idx = SLOT_IDX_BITS'(i);
      end
    end
  end

  assign out_load = (pend_r != '0) && (!out_valid_r || out_ready);
  assign pend_clr = out_load ? (slot_mask_t'(1) << pick_idx) : '0;
  assign pend_rem = pend_r & ~pend_clr;
  assign in_ready = (pend_rem == '0);
  assign in_acc   = in_valid && in_ready;
  assign pend_nxt = in_acc ? new_mask : pend_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_x_r     <= '0;
      old_y_r     <= '0;
      old_w_r     <= '0;
      old_h_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (in_acc) begin
        old_x_r <= in_new_x;
        old_y_r <= in_new_y;
        old_w_r <= in_new_w;
        old_h_r <= in_new_h;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
    if (out_load) begin
      out_reg_r  <= slot_r[pick_idx];
      out_last_r <= (pend_rem == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_region_x    = out_reg_r.x;
  assign out_region_y    = out_reg_r.y;
  assign out_region_w    = out_reg_r.w;
  assign out_region_h    = out_reg_r.h;
  assign out_is_addition = out_reg_r.add;
  assign out_last_region = out_last_r;

  // hold pending regions while the output stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && (pend_r != '0) |=> $stable(pend_r))
    else $error("pending regions changed during output stall");

  // take the next input when the final pending region moves out
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load && ($countones(pend_r) == 1) |-> in_ready)
    else $error("input not ready as last region leaves");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && (pend_r == '0))
    else $error("reset did not drop pending regions");

endmodule
